// ===== src/min_heap_timer_queue_macros.svh =====
// Assertion helpers used by the timer queue top module.
`ifndef MIN_HEAP_TIMER_QUEUE_MACROS_SVH
`define MIN_HEAP_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTH
`define MHTQ_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MHTQ_NEVER(lbl, expr, msg) \
  `MHTQ_CHECK(lbl, !(expr), msg)
`else
`define MHTQ_CHECK(lbl, prop, msg)
`define MHTQ_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/mhtq_pkg.sv =====
package mhtq_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int ID_COUNT_DEF  = 1024;
  localparam int TIME_BITS_DEF = 32;

  localparam int OP_W   = 3;
  localparam int ID_W   = 10;
  localparam int TMO_W  = 20;
  localparam int KIND_W = 3;
  localparam int REM_W  = 21;
  localparam int REM_MAX = 1048575;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_CANCEL = 3'd1,
    OP_TICK   = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_EXPIRED   = 3'd0,
    K_CANCELLED = 3'd1,
    K_NOT_FOUND = 3'd2,
    K_ADDED     = 3'd3,
    K_FULL      = 3'd4,
    K_TICK_DONE = 3'd5,
    K_NEXT      = 3'd6,
    K_CLEARED   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INSERT
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CLEAR,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_POP
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t       cmd;
    logic [ID_W-1:0] owner;
  } cell_ctrl_t;

endpackage

// ===== src/mhtq_cell.sv =====
module mhtq_cell #(
  parameter int TIME_BITS = mhtq_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mhtq_pkg::cell_ctrl_t      ctrl,
  input  logic [TIME_BITS-1:0]      new_dl,
  input  logic [TIME_BITS-1:0]      prev_dl,
  input  logic [mhtq_pkg::ID_W-1:0] prev_owner,
  input  logic                      prev_valid,
  input  logic [TIME_BITS-1:0]      next_dl,
  input  logic [mhtq_pkg::ID_W-1:0] next_owner,
  input  logic                      next_valid,
  input  logic                      ins_in,
  input  logic                      past_in,
  output logic [TIME_BITS-1:0]      dl,
  output logic [mhtq_pkg::ID_W-1:0] owner,
  output logic                      valid,
  output logic                      ins_out,
  output logic                      past_out
);

  logic [TIME_BITS-1:0] diff;
  logic                 new_first;

  assign diff      = new_dl - dl;
  assign new_first = (diff != '0) ? diff[TIME_BITS-1] : (ctrl.owner < owner);
  assign ins_out   = !valid || new_first;
  assign past_out  = past_in || (valid && owner == ctrl.owner);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.cmd)
        mhtq_pkg::CMD_CLEAR: valid <= 1'b0;
        mhtq_pkg::CMD_INSERT: begin
          if (ins_out) begin
            if (ins_in) begin
              dl    <= prev_dl;
              owner <= prev_owner;
              valid <= prev_valid;
            end else begin
              dl    <= new_dl;
              owner <= ctrl.owner;
              valid <= 1'b1;
            end
          end
        end
        mhtq_pkg::CMD_REMOVE: begin
          if (past_out) begin
            dl    <= next_dl;
            owner <= next_owner;
            valid <= next_valid;
          end
        end
        mhtq_pkg::CMD_POP: begin
          dl    <= next_dl;
          owner <= next_owner;
          valid <= next_valid;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/min_heap_timer_queue.sv =====
// Channel | Signals                                   | Direction
// input   | in_valid, in_stall, operation, id, timeout_ms | request in
// output  | out_valid, out_stall, kind, fired_id, remaining_ms, last | results out
// One request at a time; a new one is taken only once the previous finished.
// Add, cancel and clear pass through EXEC; a refresh of a present id goes
// through EXEC, then INSERT. Tick and query pop each expired timer (one pop
// per cycle from the sorted cell row). Output stalls hold the sequencer in place.
// Reset (synchronous) empties the row and zeroes the time counter.
`include "min_heap_timer_queue_macros.svh"
module min_heap_timer_queue #(
  parameter int CAPACITY  = mhtq_pkg::CAPACITY_DEF,
  parameter int ID_COUNT  = mhtq_pkg::ID_COUNT_DEF,
  parameter int TIME_BITS = mhtq_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mhtq_pkg::OP_W-1:0]        operation,
  input  logic [mhtq_pkg::ID_W-1:0]        id,
  input  logic [mhtq_pkg::TMO_W-1:0]       timeout_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mhtq_pkg::KIND_W-1:0]      kind,
  output logic [mhtq_pkg::ID_W-1:0]        fired_id,
  output logic signed [mhtq_pkg::REM_W-1:0] remaining_ms,
  output logic                             last
);

  mhtq_pkg::state_t state, state_next;
  logic [mhtq_pkg::OP_W-1:0]  op_q;
  logic [mhtq_pkg::ID_W-1:0]  id_q;
  logic [mhtq_pkg::TMO_W-1:0] tmo_q;
  logic [TIME_BITS-1:0]       now_ms;

  logic [TIME_BITS-1:0]      c_dl    [CAPACITY+1];
  logic [mhtq_pkg::ID_W-1:0] c_owner [CAPACITY+1];
  logic                      c_valid [CAPACITY+1];
  logic [CAPACITY:0]         ins_chain;
  logic [CAPACITY:0]         past_chain;
  logic [CAPACITY-1:0]       vld;

  mhtq_pkg::cell_ctrl_t ctrl;
  logic [TIME_BITS-1:0] new_dl;
  logic [TIME_BITS-1:0] head_diff;
  logic                 head_due;
  logic                 found;
  logic                 full;
  logic                 id_ok;
  logic                 accept;
  logic                 can_emit;
  logic                 emit;
  mhtq_pkg::kind_t      e_kind;
  logic [mhtq_pkg::ID_W-1:0] e_id;
  logic [mhtq_pkg::REM_W-1:0] e_rem;
  logic                 e_last;
  logic [mhtq_pkg::REM_W-1:0] rem_calc;

  assign ins_chain[0]  = 1'b0;
  assign past_chain[0] = 1'b0;
  assign c_dl[CAPACITY]    = '0;
  assign c_owner[CAPACITY] = '0;
  assign c_valid[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [TIME_BITS-1:0]      p_dl;
    logic [mhtq_pkg::ID_W-1:0] p_owner;
    logic                      p_valid;
    if (i == 0) begin : g_head
      assign p_dl    = '0;
      assign p_owner = '0;
      assign p_valid = 1'b0;
    end else begin : g_body
      assign p_dl    = c_dl[i-1];
      assign p_owner = c_owner[i-1];
      assign p_valid = c_valid[i-1];
    end
    mhtq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_dl    (new_dl),
      .prev_dl   (p_dl),
      .prev_owner(p_owner),
      .prev_valid(p_valid),
      .next_dl   (c_dl[i+1]),
      .next_owner(c_owner[i+1]),
      .next_valid(c_valid[i+1]),
      .ins_in    (ins_chain[i]),
      .past_in   (past_chain[i]),
      .dl        (c_dl[i]),
      .owner     (c_owner[i]),
      .valid     (c_valid[i]),
      .ins_out   (ins_chain[i+1]),
      .past_out  (past_chain[i+1])
    );
    assign vld[i] = c_valid[i];
  end

  assign new_dl    = now_ms + TIME_BITS'(tmo_q);
  assign head_diff = c_dl[0] - now_ms;
  assign head_due  = c_valid[0] && (head_diff[TIME_BITS-1] || head_diff == '0);
  assign found     = past_chain[CAPACITY];
  assign full      = c_valid[CAPACITY-1];
  assign id_ok     = 32'(id_q) < ID_COUNT;
  assign accept    = in_valid && !in_stall;
  assign can_emit  = !out_valid || !out_stall;
  assign in_stall  = (state != mhtq_pkg::ST_IDLE);

  always_comb begin
    if (!c_valid[0]) begin
      rem_calc = '1;
    end else if (head_diff[TIME_BITS-1]) begin
      rem_calc = '0;
    end else if (head_diff > TIME_BITS'(mhtq_pkg::REM_MAX)) begin
      rem_calc = mhtq_pkg::REM_W'(mhtq_pkg::REM_MAX);
    end else begin
      rem_calc = {1'b0, head_diff[mhtq_pkg::TMO_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhtq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl.cmd   = mhtq_pkg::CMD_HOLD;
    ctrl.owner = id_q;
    emit   = 1'b0;
    e_kind = mhtq_pkg::K_EXPIRED;
    e_id   = '0;
    e_rem  = '0;
    e_last = 1'b1;
    unique case (state)
      mhtq_pkg::ST_IDLE: begin
        if (accept && operation <= mhtq_pkg::OP_CLEAR) begin
          state_next = mhtq_pkg::ST_EXEC;
        end
      end
      mhtq_pkg::ST_EXEC: begin
        unique case (op_q)
          mhtq_pkg::OP_ADD: begin
            if (id_ok && found) begin
              // refresh: drop the old entry, insert in ST_INSERT
              ctrl.cmd   = mhtq_pkg::CMD_REMOVE;
              state_next = mhtq_pkg::ST_INSERT;
            end else if (can_emit) begin
              emit       = 1'b1;
              state_next = mhtq_pkg::ST_IDLE;
              if (!id_ok || full) begin
                e_kind = mhtq_pkg::K_FULL;
              end else begin
                ctrl.cmd = mhtq_pkg::CMD_INSERT;
                e_kind   = mhtq_pkg::K_ADDED;
                e_id     = id_q;
              end
            end
          end
          mhtq_pkg::OP_CANCEL: begin
            if (can_emit) begin
              emit       = 1'b1;
              state_next = mhtq_pkg::ST_IDLE;
              if (id_ok && found) begin
                ctrl.cmd = mhtq_pkg::CMD_REMOVE;
                e_kind   = mhtq_pkg::K_CANCELLED;
                e_id     = id_q;
              end else begin
                e_kind = mhtq_pkg::K_NOT_FOUND;
              end
            end
          end
          mhtq_pkg::OP_TICK, mhtq_pkg::OP_QUERY: begin
            if (can_emit) begin
              emit = 1'b1;
              if (head_due) begin
                ctrl.cmd = mhtq_pkg::CMD_POP;
                e_kind   = mhtq_pkg::K_EXPIRED;
                e_id     = c_owner[0];
                e_last   = 1'b0;
              end else begin
                state_next = mhtq_pkg::ST_IDLE;
                if (op_q == mhtq_pkg::OP_TICK) begin
                  e_kind = mhtq_pkg::K_TICK_DONE;
                end else begin
                  e_kind = mhtq_pkg::K_NEXT;
                  e_rem  = rem_calc;
                end
              end
            end
          end
          default: begin
            if (can_emit) begin
              emit       = 1'b1;
              ctrl.cmd   = mhtq_pkg::CMD_CLEAR;
              e_kind     = mhtq_pkg::K_CLEARED;
              state_next = mhtq_pkg::ST_IDLE;
            end
          end
        endcase
      end
      mhtq_pkg::ST_INSERT: begin
        if (can_emit) begin
          ctrl.cmd   = mhtq_pkg::CMD_INSERT;
          emit       = 1'b1;
          e_kind     = mhtq_pkg::K_ADDED;
          e_id       = id_q;
          state_next = mhtq_pkg::ST_IDLE;
        end
      end
      default: state_next = mhtq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
    end else if (accept && operation == mhtq_pkg::OP_TICK) begin
      now_ms <= now_ms + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      id_q  <= id;
      tmo_q <= timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= e_kind;
      fired_id     <= e_id;
      remaining_ms <= e_rem;
      last         <= e_last;
    end
  end

  `MHTQ_NEVER(a_idle_no_emit, !in_stall && emit, "result from idle sequencer")
  `MHTQ_NEVER(a_row_packed, (vld & (vld + 1'b1)) != '0, "hole in cell row")
  `MHTQ_CHECK(a_insert_done, state == mhtq_pkg::ST_INSERT && can_emit |=> !in_stall, "insert hung")
  `MHTQ_NEVER(a_emit_overrun, emit && out_valid && out_stall, "result overwrote a stalled one")

endmodule
